// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the interval table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/dbit_pkg.sv
// Shared types and status codes of the double-booking interval table.
package dbit_pkg;

   typedef struct packed {
      logic        valid;
      logic [31:0] lo;
      logic [31:0] hi;
   } entry_type;

   localparam logic [1:0] STATUS_BOOKED = 2'd0;
   localparam logic [1:0] STATUS_TRIPLE = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

endpackage

// File: hdl/dbit_if.sv
// Request and response channel interfaces of the interval table.
interface dbit_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] req_start;
   logic [31:0] req_end;

   modport source (output valid, output req_start, output req_end, input ready);
   modport sink   (input valid, input req_start, input req_end, output ready);
endinterface

interface dbit_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

// File: hdl/dbit_cell.sv
// One storage cell of an interval chain: takes its neighbor's entry when shifted.
module dbit_cell import dbit_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_en,
   input  entry_type d_in,
   output entry_type q_out
);

   logic        valid_ff;
   logic [31:0] lo_ff;
   logic [31:0] hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= d_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         lo_ff <= d_in.lo;
         hi_ff <= d_in.hi;
      end
   end

   assign q_out = '{valid: valid_ff, lo: lo_ff, hi: hi_ff};

endmodule

// File: hdl/dbit_olap.sv
// Intersection of the held request with one stored interval.
module dbit_olap import dbit_pkg::*; (
   input  logic [31:0] req_lo,
   input  logic [31:0] req_hi,
   input  entry_type   stored,
   output entry_type   ovl
);

   logic [31:0] lo;
   logic [31:0] hi;

   always_comb begin
      lo = (req_lo > stored.lo) ? req_lo : stored.lo;
      hi = (req_hi < stored.hi) ? req_hi : stored.hi;
   end

   // touching intervals do not overlap
   assign ovl = '{valid: stored.valid && (lo < hi), lo: lo, hi: hi};

endmodule

// File: hdl/double_booking_interval_table_unit.sv
// Top level of the double-booking interval table: sequencer and two cell chains.
//
//   channel  dir  handshake          payload
//   req_bus  in   valid/ready        req_start[31:0], req_end[31:0]
//   rsp_bus  out  valid/ready        status[1:0]
//
// Between request beats the sequencer passes idle, a scan lap of each cell chain past
// its tail compare unit and the response state; a booking adds an append step, and a
// booking that overlaps a stored one adds an insert lap of the booking chain before it.
// Reset clears the valid bits and counts at once; no clearing pass.
// One request is in work at a time; a finished beat waits in the response register
// and the next request is accepted while it waits. A stalled response holds the
// sequencer only when the next status is ready to go out.
`include "assert_macros.svh"

module double_booking_interval_table_unit import dbit_pkg::*; #(
   parameter int BOOKING_DEPTH = 64,
   parameter int DOUBLE_DEPTH  = 64
) (
   input  logic      clock,
   input  logic      reset,
   dbit_req_if.sink  req_bus,
   dbit_rsp_if.source rsp_bus
);

   localparam int MAX_DEPTH = (BOOKING_DEPTH > DOUBLE_DEPTH) ? BOOKING_DEPTH : DOUBLE_DEPTH;
   localparam int CNT_W     = $clog2(MAX_DEPTH);
   localparam int BCNT_W    = $clog2(BOOKING_DEPTH + 1);
   localparam int DCNT_W    = $clog2(DOUBLE_DEPTH + 1);
   localparam int SUM_W     = ((BCNT_W > DCNT_W) ? BCNT_W : DCNT_W) + 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_INSERT = 5'b00100,
      ST_APPEND = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       req_lo_ff, req_lo_in;
   logic [31:0]       req_hi_ff, req_hi_in;
   logic              triple_ff, triple_in;
   logic [BCNT_W-1:0] added_ff, added_in;
   logic [BCNT_W-1:0] booked_count_ff, booked_count_in;
   logic [DCNT_W-1:0] double_count_ff, double_count_in;
   logic [1:0]        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // chain storage
   entry_type bk_q  [BOOKING_DEPTH];
   entry_type bk_d  [BOOKING_DEPTH];
   entry_type dbl_q [DOUBLE_DEPTH];
   entry_type dbl_d [DOUBLE_DEPTH];
   entry_type bk_ovl;
   entry_type dbl_ovl;

   logic bk_run;
   logic dbl_run;
   logic bk_shift;
   logic dbl_shift;
   logic bk_hit;
   logic scan_last;
   logic store_full;

   // chains rotate through their tail during the scan; a full lap restores them
   assign bk_run   = {1'b0, cnt_ff} < (CNT_W + 1)'(BOOKING_DEPTH);
   assign dbl_run  = {1'b0, cnt_ff} < (CNT_W + 1)'(DOUBLE_DEPTH);
   assign scan_last = cnt_ff == CNT_W'(MAX_DEPTH - 1);
   // booking at the tail overlaps the request during the scan
   assign bk_hit   = bk_run && bk_ovl.valid;

   assign bk_shift  = ((state_ff == ST_SCAN) && bk_run) || (state_ff == ST_INSERT)
                      || (state_ff == ST_APPEND);
   // on insert the lap of the booking chain pushes each overlap into the double chain
   assign dbl_shift = ((state_ff == ST_SCAN) && dbl_run)
                      || ((state_ff == ST_INSERT) && bk_ovl.valid);

   always_comb begin
      bk_d[0] = (state_ff == ST_APPEND) ? entry_type'{valid: 1'b1, lo: req_lo_ff, hi: req_hi_ff}
                                        : bk_q[BOOKING_DEPTH-1];
      for (int i = 1; i < BOOKING_DEPTH; i++) begin
         bk_d[i] = bk_q[i-1];
      end
      dbl_d[0] = (state_ff == ST_INSERT) ? bk_ovl : dbl_q[DOUBLE_DEPTH-1];
      for (int i = 1; i < DOUBLE_DEPTH; i++) begin
         dbl_d[i] = dbl_q[i-1];
      end
   end

   for (genvar g = 0; g < BOOKING_DEPTH; g++) begin : g_bk
      dbit_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (bk_shift),
         .d_in     (bk_d[g]),
         .q_out    (bk_q[g])
      );
   end

   for (genvar g = 0; g < DOUBLE_DEPTH; g++) begin : g_dbl
      dbit_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (dbl_shift),
         .d_in     (dbl_d[g]),
         .q_out    (dbl_q[g])
      );
   end

   dbit_olap u_bk_olap (
      .req_lo (req_lo_ff),
      .req_hi (req_hi_ff),
      .stored (bk_q[BOOKING_DEPTH-1]),
      .ovl    (bk_ovl)
   );

   dbit_olap u_dbl_olap (
      .req_lo (req_lo_ff),
      .req_hi (req_hi_ff),
      .stored (dbl_q[DOUBLE_DEPTH-1]),
      .ovl    (dbl_ovl)
   );

   // full test: booking store at capacity, or the new overlaps would not fit
   assign store_full = (booked_count_ff == BCNT_W'(BOOKING_DEPTH))
                       || ((SUM_W'(double_count_ff) + SUM_W'(added_ff) + SUM_W'(bk_hit))
                           > SUM_W'(DOUBLE_DEPTH));

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      req_lo_in       = req_lo_ff;
      req_hi_in       = req_hi_ff;
      triple_in       = triple_ff;
      added_in        = added_ff;
      booked_count_in = booked_count_ff;
      double_count_in = double_count_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in   = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               req_lo_in = req_bus.req_start;
               req_hi_in = req_bus.req_end;
               cnt_in    = '0;
               triple_in = 1'b0;
               added_in  = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (dbl_run && dbl_ovl.valid) begin
               triple_in = 1'b1;
            end
            if (bk_hit) begin
               added_in = added_ff + BCNT_W'(1);
            end
            if (scan_last) begin
               cnt_in = '0;
               if (triple_in) begin
                  status_in = STATUS_TRIPLE;
                  state_in  = ST_RESP;
               end else if (store_full) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_RESP;
               end else if (added_in == '0) begin
                  state_in = ST_APPEND;
               end else begin
                  state_in = ST_INSERT;
               end
            end
         end
         ST_INSERT: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (bk_ovl.valid) begin
               double_count_in = double_count_ff + DCNT_W'(1);
            end
            if (cnt_ff == CNT_W'(BOOKING_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            booked_count_in = booked_count_ff + BCNT_W'(1);
            status_in       = STATUS_BOOKED;
            state_in        = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         booked_count_ff <= '0;
         double_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         triple_ff       <= 1'b0;
         added_ff        <= '0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         booked_count_ff <= booked_count_in;
         double_count_ff <= double_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         triple_ff       <= triple_in;
         added_ff        <= added_in;
      end
   end

   always_ff @(posedge clock) begin
      req_lo_ff     <= req_lo_in;
      req_hi_ff     <= req_hi_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_bus.ready  = state_ff == ST_IDLE;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;

   `ASSERT_ALWAYS(a_bk_count_bound, clock, reset, booked_count_ff <= BCNT_W'(BOOKING_DEPTH), "booking count past depth")
   `ASSERT_ALWAYS(a_dbl_count_bound, clock, reset, double_count_ff <= DCNT_W'(DOUBLE_DEPTH), "double count past depth")
   `ASSERT_IMPLIES(a_insert_room, clock, reset, dbl_shift && (state_ff == ST_INSERT), double_count_ff < DCNT_W'(DOUBLE_DEPTH), "overlap pushed into full double chain")
   `ASSERT_NEXT(a_accept_scan, clock, reset, req_bus.valid && req_bus.ready, state_ff == ST_SCAN, "accepted request did not start scan")

endmodule
